// ===== rtl/core/bitmap_page_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// Bitmap page allocator assertion macros
// Shorthand for the clocked checks used in the allocator's RTL.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPA_ASSERT_SAME(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPA_ASSERT_NEXT(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Operation and status codes, field widths and the word unit result type.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

    localparam int OP_W     = 3;
    localparam int PAGE_W   = 20;
    localparam int END_W    = 21;
    localparam int POS_W    = 21;
    localparam int COUNT_W  = 16;
    localparam int GRANT_W  = 15;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 32;
    localparam int BIT_W    = 5;
    localparam int POP_W    = 6;

    localparam logic [OP_W-1:0] OP_ALLOC = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd2;
    localparam logic [OP_W-1:0] OP_ADD   = 3'd3;
    localparam logic [OP_W-1:0] OP_RESET = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_DOUBLE  = 2'd3;

    localparam logic [COUNT_W-1:0] FREE_MAX = 16'hFFFF;
    localparam logic [WORD_W-1:0]  ALL_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic               found;
        logic [BIT_W-1:0]   bit_index;
        logic [POP_W-1:0]   freed;
        logic [WORD_W-1:0]  alloc_word;
        logic [WORD_W-1:0]  release_word;
    } word_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/bpa_map_ram.sv =====
// ----------------------------------------------------------------------------
// Usage map memory
// One word per 32 pages, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_map_ram #(
    parameter int WORDS  = 1024,
    parameter int ADDR_W = 10
) (
    input  wire logic                       clk,
    input  wire logic                       rd_en,
    input  wire logic [ADDR_W-1:0]          rd_addr,
    output logic [bpa_pkg::WORD_W-1:0]      rd_data,
    input  wire logic                       wr_en,
    input  wire logic [ADDR_W-1:0]          wr_addr,
    input  wire logic [bpa_pkg::WORD_W-1:0] wr_data
);
    import bpa_pkg::*;

    logic [WORD_W-1:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/bpa_word_unit.sv =====
// ----------------------------------------------------------------------------
// Map word unit
// Finds the lowest free page in a masked word and counts used pages in it.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_word_unit (
    input  wire logic [bpa_pkg::WORD_W-1:0] map_word,
    input  wire logic [bpa_pkg::WORD_W-1:0] range_mask,
    output bpa_pkg::word_result_t           result
);
    import bpa_pkg::*;

    logic [WORD_W-1:0] free_bits;
    logic [WORD_W-1:0] lowest;
    logic [WORD_W-1:0] used_bits;
    logic [BIT_W-1:0]  index;
    logic [POP_W-1:0]  pop;

    always_comb
    begin
        free_bits = ~map_word & range_mask;
        // Two's complement trick isolates the lowest set bit.
        lowest    = free_bits & (~free_bits + WORD_W'(1));
        used_bits = map_word & range_mask;
        index     = '0;
        pop       = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (lowest[i])
            begin
                index = index | BIT_W'(i);
            end
            pop = pop + POP_W'(used_bits[i]);
        end
        result.found        = |free_bits;
        result.bit_index    = index;
        result.freed        = pop;
        result.alloc_word   = map_word | lowest;
        result.release_word = map_word & ~range_mask;
    end

endmodule

`default_nettype wire

// ===== rtl/core/bitmap_page_allocator.sv =====
// ----------------------------------------------------------------------------
// Bitmap page allocator
// Sequencer around a one-bit-per-page usage map held in a synchronous memory.
// ----------------------------------------------------------------------------
// One request is taken when start is high and busy is low; its result appears
// on the result ports for exactly one cycle with done high, and the receiver
// cannot hold it off. The usage map lives in a memory of PAGE_CAPACITY/32
// words with a registered read port: free reads the page's word, then checks
// it and writes it back if the page was used; allocate reads and checks map
// words in turn until one has a free page or the range ends; add region reads
// and writes back each word, then folds in the last count; clear and reset
// write every map word; invalid or empty requests finish straight from idle.
// After reset the block runs a clearing pass that marks every page used, one
// word per cycle, with busy high; the floor register may be written at any time the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bitmap_page_allocator_defines.svh"

module bitmap_page_allocator #(
    parameter int PAGE_CAPACITY = 32768
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [bpa_pkg::OP_W-1:0]     operation,
    input  wire logic [bpa_pkg::PAGE_W-1:0]   page_number,
    input  wire logic [bpa_pkg::END_W-1:0]    region_end,
    input  wire logic                         cfg_write,
    input  wire logic [bpa_pkg::COUNT_W-1:0]  cfg_data,
    output logic                              done,
    output logic [bpa_pkg::GRANT_W-1:0]       granted_page,
    output logic [bpa_pkg::STATUS_W-1:0]      status,
    output logic [bpa_pkg::COUNT_W-1:0]       free_count,
    output logic [bpa_pkg::COUNT_W-1:0]       top_page
);
    import bpa_pkg::*;

    localparam int WORDS  = (PAGE_CAPACITY + WORD_W - 1) / WORD_W;
    localparam int ADDR_W = $clog2(WORDS);
    localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(WORDS - 1);
    localparam logic [POS_W-1:0]  CAP_POS   = POS_W'(PAGE_CAPACITY);

    localparam logic [3:0] S_INIT      = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_ALLOC_RD  = 4'd2;
    localparam logic [3:0] S_ALLOC_CHK = 4'd3;
    localparam logic [3:0] S_FREE_RD   = 4'd4;
    localparam logic [3:0] S_FREE_CHK  = 4'd5;
    localparam logic [3:0] S_FILL      = 4'd6;
    localparam logic [3:0] S_RGN_RD    = 4'd7;
    localparam logic [3:0] S_RGN_MOD   = 4'd8;
    localparam logic [3:0] S_RGN_END   = 4'd9;

    logic [3:0]          state_reg, state_next;
    logic [ADDR_W-1:0]   word_reg, word_next;
    logic [ADDR_W-1:0]   last_word_reg, last_word_next;
    logic [BIT_W-1:0]    lo_bit_reg, lo_bit_next;
    logic [BIT_W-1:0]    last_bit_reg, last_bit_next;
    logic                first_reg, first_next;
    logic                fill_ones_reg, fill_ones_next;
    logic [POP_W-1:0]    pend_reg, pend_next;
    logic [COUNT_W-1:0]  free_reg, free_next;
    logic [COUNT_W-1:0]  top_reg, top_next;
    logic [COUNT_W-1:0]  floor_reg;
    logic                done_reg, done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [GRANT_W-1:0]  granted_reg, granted_next;

    logic                ram_rd_en;
    logic                ram_wr_en;
    logic [WORD_W-1:0]   ram_wr_data;
    logic [WORD_W-1:0]   ram_rd_data;

    logic [WORD_W-1:0]   lo_mask;
    logic [WORD_W-1:0]   hi_mask;
    logic [WORD_W-1:0]   range_mask;
    logic [WORD_W-1:0]   fill_pattern;
    word_result_t        unit_result;

    logic                accept;
    logic                at_last;
    logic [POS_W-1:0]    pg_pos, floor_pos, top_pos, end_pos;
    logic [POS_W-1:0]    range_lo, range_hi, hi_m1;
    logic [POS_W-1:0]    word_pos, floor_word_pos, grant_pos;
    logic [COUNT_W:0]    pend_sum;
    logic [COUNT_W-1:0]  free_plus;
    logic [COUNT_W-1:0]  free_inc;
    logic [COUNT_W-1:0]  free_dec;

    bpa_map_ram #(
        .WORDS  (WORDS),
        .ADDR_W (ADDR_W)
    ) u_map_ram (
        .clk     (clk),
        .rd_en   (ram_rd_en),
        .rd_addr (word_reg),
        .rd_data (ram_rd_data),
        .wr_en   (ram_wr_en),
        .wr_addr (word_reg),
        .wr_data (ram_wr_data)
    );

    bpa_word_unit u_word_unit (
        .map_word   (ram_rd_data),
        .range_mask (range_mask),
        .result     (unit_result)
    );

    assign busy         = (state_reg != S_IDLE);
    assign accept       = start && !busy;
    assign done         = done_reg;
    assign status       = status_reg;
    assign granted_page = granted_reg;
    assign free_count   = free_reg;
    assign top_page     = top_reg;
    assign at_last      = (word_reg == last_word_reg);

    // Range of pages in the current word: the first word starts at the low
    // bound, the last word stops at the high bound.
    always_comb
    begin
        lo_mask    = first_reg ? (ALL_ONES << lo_bit_reg) : ALL_ONES;
        hi_mask    = at_last ? (ALL_ONES >> (BIT_W'(WORD_W - 1) - last_bit_reg)) : ALL_ONES;
        range_mask = lo_mask & hi_mask;
    end

    // Fill pattern: a clear marks every page used; a reset keeps pages below the floor used.
    always_comb
    begin
        word_pos       = POS_W'(word_reg);
        floor_word_pos = POS_W'(floor_reg[COUNT_W-1:BIT_W]);
        if (fill_ones_reg || (word_pos < floor_word_pos))
        begin
            fill_pattern = ALL_ONES;
        end
        else if (word_pos == floor_word_pos)
        begin
            fill_pattern = ~(ALL_ONES << floor_reg[BIT_W-1:0]);
        end
        else
        begin
            fill_pattern = '0;
        end
    end

    always_comb
    begin
        pend_sum  = {1'b0, free_reg} + (COUNT_W + 1)'(pend_reg);
        free_plus = pend_sum[COUNT_W] ? FREE_MAX : pend_sum[COUNT_W-1:0];
        free_inc  = (free_reg == FREE_MAX) ? FREE_MAX : free_reg + COUNT_W'(1);
        free_dec  = (free_reg == '0) ? '0 : free_reg - COUNT_W'(1);
        grant_pos = (POS_W'(word_reg) << BIT_W) | POS_W'(unit_result.bit_index);

        pg_pos    = POS_W'(page_number);
        floor_pos = POS_W'(floor_reg);
        top_pos   = POS_W'(top_reg);
        end_pos   = POS_W'(region_end);
        case (operation)
            OP_ALLOC:
            begin
                range_lo = floor_pos;
                range_hi = (top_pos < CAP_POS) ? top_pos : CAP_POS;
            end
            OP_ADD:
            begin
                range_lo = (pg_pos < floor_pos) ? floor_pos : pg_pos;
                range_hi = (end_pos < CAP_POS) ? end_pos : CAP_POS;
            end
            default:
            begin
                range_lo = pg_pos;
                range_hi = pg_pos + POS_W'(1);
            end
        endcase
        hi_m1 = range_hi - POS_W'(1);
    end

    always_comb
    begin
        state_next     = state_reg;
        word_next      = word_reg;
        last_word_next = last_word_reg;
        lo_bit_next    = lo_bit_reg;
        last_bit_next  = last_bit_reg;
        first_next     = first_reg;
        fill_ones_next = fill_ones_reg;
        pend_next      = pend_reg;
        free_next      = free_reg;
        top_next       = top_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        granted_next   = granted_reg;
        ram_rd_en      = 1'b0;
        ram_wr_en      = 1'b0;
        ram_wr_data    = unit_result.release_word;

        case (state_reg)
            S_INIT:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_data = ALL_ONES;
                if (word_reg == LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    word_next = word_reg + ADDR_W'(1);
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next    = STATUS_OK;
                    granted_next   = '0;
                    word_next      = range_lo[ADDR_W+BIT_W-1:BIT_W];
                    lo_bit_next    = range_lo[BIT_W-1:0];
                    last_word_next = hi_m1[ADDR_W+BIT_W-1:BIT_W];
                    last_bit_next  = hi_m1[BIT_W-1:0];
                    first_next     = 1'b1;
                    pend_next      = '0;
                    case (operation)
                        OP_ALLOC:
                        begin
                            if (range_lo < range_hi)
                            begin
                                state_next = S_ALLOC_RD;
                            end
                            else
                            begin
                                status_next = STATUS_NO_FREE;
                                done_next   = 1'b1;
                            end
                        end
                        OP_FREE:
                        begin
                            if ((pg_pos < floor_pos) || (pg_pos >= top_pos)
                                || (pg_pos >= CAP_POS))
                            begin
                                status_next = STATUS_INVALID;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_FREE_RD;
                            end
                        end
                        OP_CLEAR:
                        begin
                            word_next      = '0;
                            fill_ones_next = 1'b1;
                            free_next      = '0;
                            state_next     = S_FILL;
                        end
                        OP_ADD:
                        begin
                            if ((end_pos > top_pos) && (end_pos <= CAP_POS))
                            begin
                                top_next = region_end[COUNT_W-1:0];
                            end
                            if (range_lo < range_hi)
                            begin
                                state_next = S_RGN_RD;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        OP_RESET:
                        begin
                            word_next      = '0;
                            fill_ones_next = 1'b0;
                            free_next      = (top_reg > floor_reg) ? top_reg - floor_reg : '0;
                            state_next     = S_FILL;
                        end
                        default:
                        begin
                            status_next = STATUS_INVALID;
                            done_next   = 1'b1;
                        end
                    endcase
                end
            end
            S_ALLOC_RD:
            begin
                ram_rd_en  = 1'b1;
                state_next = S_ALLOC_CHK;
            end
            S_ALLOC_CHK:
            begin
                if (unit_result.found)
                begin
                    ram_wr_en    = 1'b1;
                    ram_wr_data  = unit_result.alloc_word;
                    free_next    = free_dec;
                    granted_next = grant_pos[GRANT_W-1:0];
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (at_last)
                begin
                    status_next = STATUS_NO_FREE;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    word_next  = word_reg + ADDR_W'(1);
                    first_next = 1'b0;
                    state_next = S_ALLOC_RD;
                end
            end
            S_FREE_RD:
            begin
                ram_rd_en  = 1'b1;
                state_next = S_FREE_CHK;
            end
            S_FREE_CHK:
            begin
                // The range mask covers exactly the requested page here.
                if (unit_result.freed == '0)
                begin
                    status_next = STATUS_DOUBLE;
                end
                else
                begin
                    ram_wr_en = 1'b1;
                    free_next = free_inc;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_FILL:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_data = fill_pattern;
                if (word_reg == LAST_WORD)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    word_next = word_reg + ADDR_W'(1);
                end
            end
            S_RGN_RD:
            begin
                // Fold in the pages released from the previous word.
                ram_rd_en  = 1'b1;
                free_next  = free_plus;
                state_next = S_RGN_MOD;
            end
            S_RGN_MOD:
            begin
                ram_wr_en = 1'b1;
                pend_next = unit_result.freed;
                if (at_last)
                begin
                    state_next = S_RGN_END;
                end
                else
                begin
                    word_next  = word_reg + ADDR_W'(1);
                    first_next = 1'b0;
                    state_next = S_RGN_RD;
                end
            end
            S_RGN_END:
            begin
                free_next  = free_plus;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            word_reg  <= '0;
            free_reg  <= '0;
            top_reg   <= '0;
            floor_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            word_reg  <= word_next;
            free_reg  <= free_next;
            top_reg   <= top_next;
            done_reg  <= done_next;
            if (cfg_write)
            begin
                floor_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        last_word_reg <= last_word_next;
        lo_bit_reg    <= lo_bit_next;
        last_bit_reg  <= last_bit_next;
        first_reg     <= first_next;
        fill_ones_reg <= fill_ones_next;
        pend_reg      <= pend_next;
        status_reg    <= status_next;
        granted_reg   <= granted_next;
    end

    `BPA_ASSERT_NEXT(a_accept_goes_busy, clk, rst_n, start && !busy, busy || done, "request accepted but neither busy nor done")
    `BPA_ASSERT_SAME(a_done_after_work, clk, rst_n, done, $past(state_reg) != S_INIT, "result strobe right after the clearing pass")
    `BPA_ASSERT_SAME(a_map_write_busy, clk, rst_n, ram_wr_en, state_reg != S_IDLE, "map written while idle")
    `BPA_ASSERT_SAME(a_grant_only_ok, clk, rst_n, done && (status != STATUS_OK), granted_page == '0, "page granted with a failing status")

endmodule

`default_nettype wire

// ===== dv/tb_bitmap_page_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page allocator testbench
// Drives a short table of directed requests and then phases of random ones
// through the start/busy port. A behavioral copy of the usage map, free count
// and top page predicts untyped results; each is checked field by field.
// ----------------------------------------------------------------------------

module tb_bitmap_page_allocator;

    import bpa_pkg::*;

    localparam int PAGE_CAP       = 32768;
    localparam int MAP_WORDS      = PAGE_CAP / WORD_W;
    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 6;
    localparam int GAP_MAX        = 8;
    localparam int TOTAL_REQUESTS = 1150;
    // Longest operation is an add region over the whole map.
    localparam int SETTLE_CYCLES  = 2200;
    localparam int PRINT_CAP      = 100;
    localparam longint LIMIT_NS   = 250_000_000;

    // Operation codes that the block rejects.
    localparam logic [OP_W-1:0] OP_UNUSED_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [GRANT_W-1:0]  granted;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  free_cnt;
        logic [COUNT_W-1:0]  top;
    } alloc_result_t;

    typedef enum bit {ROW_REQUEST, ROW_FLOOR} row_kind_e;

    typedef struct {
        row_kind_e          kind;
        logic [OP_W-1:0]    op;
        logic [PAGE_W-1:0]  page;
        logic [END_W-1:0]   region;
        bit                 typed;
        alloc_result_t      want;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [OP_W-1:0]      operation = OP_ALLOC;
    logic [PAGE_W-1:0]    page_number = '0;
    logic [END_W-1:0]     region_end = '0;
    logic                 cfg_write = 1'b0;
    logic [COUNT_W-1:0]   cfg_data = '0;
    logic                 busy;
    logic                 done;
    logic [GRANT_W-1:0]   granted_page;
    logic [STATUS_W-1:0]  status;
    logic [COUNT_W-1:0]   free_count;
    logic [COUNT_W-1:0]   top_page;

    // Predicted allocator state.
    logic [WORD_W-1:0]    page_map [MAP_WORDS];
    logic [COUNT_W-1:0]   model_free;
    logic [COUNT_W-1:0]   model_top;
    logic [COUNT_W-1:0]   model_floor;

    alloc_result_t        awaited_results [$];
    stim_row_t            directed_rows [$];
    int unsigned          claimed_pages [$];
    int                   mismatch_count = 0;
    int                   issued = 0;

    bitmap_page_allocator #(
        .PAGE_CAPACITY(PAGE_CAP)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .page_number  (page_number),
        .region_end   (region_end),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .done         (done),
        .granted_page (granted_page),
        .status       (status),
        .free_count   (free_count),
        .top_page     (top_page)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic bit page_is_used(input int unsigned p);
        if (p >= PAGE_CAP)
        begin
            return 1'b1;
        end
        return page_map[p / WORD_W][p % WORD_W];
    endfunction

    function automatic void mark_page(input int unsigned p, input bit used);
        if (p < PAGE_CAP)
        begin
            page_map[p / WORD_W][p % WORD_W] = used;
        end
    endfunction

    function automatic alloc_result_t compute_page_result(input logic [OP_W-1:0] op,
                                                          input logic [PAGE_W-1:0] page,
                                                          input logic [END_W-1:0] region);
        alloc_result_t res;
        int unsigned   p;
        int unsigned   lim;
        res = '0;
        case (op)
            OP_ALLOC:
            begin
                lim = (model_top < PAGE_CAP) ? model_top : PAGE_CAP;
                p = model_floor;
                res.status = STATUS_NO_FREE;
                while (p < lim)
                begin
                    // Whole words that are fully used can be skipped at once.
                    if ((p % WORD_W) == 0 && page_map[p / WORD_W] == ALL_ONES)
                    begin
                        p = p + WORD_W;
                    end
                    else if (!page_is_used(p))
                    begin
                        mark_page(p, 1'b1);
                        if (model_free != 0)
                        begin
                            model_free = model_free - 1'b1;
                        end
                        res.granted = p[GRANT_W-1:0];
                        res.status = STATUS_OK;
                        break;
                    end
                    else
                    begin
                        p = p + 1;
                    end
                end
            end
            OP_FREE:
            begin
                if (page < model_floor || page >= model_top || page >= PAGE_CAP)
                begin
                    res.status = STATUS_INVALID;
                end
                else if (!page_is_used(page))
                begin
                    res.status = STATUS_DOUBLE;
                end
                else
                begin
                    mark_page(page, 1'b0);
                    if (model_free != FREE_MAX)
                    begin
                        model_free = model_free + 1'b1;
                    end
                end
            end
            OP_CLEAR:
            begin
                foreach (page_map[w])
                begin
                    page_map[w] = ALL_ONES;
                end
                model_free = '0;
            end
            OP_ADD:
            begin
                p = (page < model_floor) ? model_floor : page;
                lim = (region < PAGE_CAP) ? region : PAGE_CAP;
                for (; p < lim; p++)
                begin
                    if (page_is_used(p))
                    begin
                        mark_page(p, 1'b0);
                        if (model_free != FREE_MAX)
                        begin
                            model_free = model_free + 1'b1;
                        end
                    end
                end
                if (region > model_top && region <= PAGE_CAP)
                begin
                    model_top = region[COUNT_W-1:0];
                end
            end
            OP_RESET:
            begin
                for (p = 0; p < PAGE_CAP; p++)
                begin
                    mark_page(p, p < model_floor);
                end
                model_free = (model_top > model_floor) ? model_top - model_floor : '0;
            end
            default:
            begin
                res.status = STATUS_INVALID;
            end
        endcase
        res.free_cnt = model_free;
        res.top = model_top;
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        if (mismatch_count < PRINT_CAP)
        begin
            $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : result_check
        alloc_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (awaited_results.size() == 0)
            begin
                flag_mismatch("result with no request pending", granted_page, 0);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (granted_page !== want.granted)
                begin
                    flag_mismatch("granted_page", granted_page, want.granted);
                end
                if (status !== want.status)
                begin
                    flag_mismatch("status", status, want.status);
                end
                if (free_count !== want.free_cnt)
                begin
                    flag_mismatch("free_count", free_count, want.free_cnt);
                end
                if (top_page !== want.top)
                begin
                    flag_mismatch("top_page", top_page, want.top);
                end
            end
        end
    end

    // Holds the request on the ports until the block takes it, then records
    // what it should answer. A typed row's expectation replaces the prediction.
    task automatic issue_request(input logic [OP_W-1:0] op, input logic [PAGE_W-1:0] page,
                                 input logic [END_W-1:0] region, input bit typed,
                                 input alloc_result_t typed_want);
        alloc_result_t predicted;
        operation <= op;
        page_number <= page;
        region_end <= region;
        start <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
        predicted = compute_page_result(op, page, region);
        awaited_results.push_back(typed ? typed_want : predicted);
        issued++;
        if (op == OP_ALLOC && predicted.status == STATUS_OK)
        begin
            claimed_pages.push_back(predicted.granted);
        end
        else if (op == OP_RESET)
        begin
            claimed_pages.delete();
        end
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (awaited_results.size() != 0 || busy !== 1'b0);
    endtask

    task automatic set_floor(input logic [COUNT_W-1:0] value);
        wait_all_results();
        cfg_data <= value;
        cfg_write <= 1'b1;
        @(posedge clk);
        cfg_write <= 1'b0;
        model_floor = value;
    endtask

    task automatic put_row(input row_kind_e kind, input logic [OP_W-1:0] op,
                           input int unsigned page, input int unsigned region,
                           input bit typed, input int unsigned granted,
                           input logic [STATUS_W-1:0] st, input int unsigned fc,
                           input int unsigned tp);
        stim_row_t row;
        row.kind = kind;
        row.op = op;
        row.page = page[PAGE_W-1:0];
        row.region = region[END_W-1:0];
        row.typed = typed;
        row.want.granted = granted[GRANT_W-1:0];
        row.want.status = st;
        row.want.free_cnt = fc[COUNT_W-1:0];
        row.want.top = tp[COUNT_W-1:0];
        directed_rows.push_back(row);
    endtask

    // Frees a modest region a little above the floor; now and then an empty
    // region or one that ends anywhere up to the map's capacity.
    task automatic add_near_floor();
        int unsigned first;
        int unsigned last;
        int          pick;
        first = model_floor + $urandom_range(0, 4096);
        pick = $urandom_range(0, 19);
        if (pick < 2)
        begin
            last = $urandom_range(0, first);
        end
        else if (pick == 2)
        begin
            last = $urandom_range(first, PAGE_CAP);
        end
        else
        begin
            last = first + $urandom_range(0, 256);
        end
        issue_request(OP_ADD, first[PAGE_W-1:0], last[END_W-1:0], 1'b0, '0);
    endtask

    initial
    begin : timeout_guard
        #LIMIT_NS;
        $display("bitmap_page_allocator: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        int          pick;
        int          steps;
        int          gap_top;
        int          idx;
        int unsigned page;
        int unsigned region;

        foreach (page_map[w])
        begin
            page_map[w] = ALL_ONES;
        end
        model_free = '0;
        model_top = '0;
        model_floor = '0;

        // kind, op, page, region, typed, granted, status, free, top
        put_row(ROW_REQUEST, OP_ALLOC, 0, 0, 1, 0, STATUS_NO_FREE, 0, 0);
        put_row(ROW_REQUEST, OP_FREE, 0, 0, 1, 0, STATUS_INVALID, 0, 0);
        put_row(ROW_REQUEST, OP_UNUSED_7, 20'hFFFFF, 1048576, 1, 0, STATUS_INVALID, 0, 0);
        put_row(ROW_REQUEST, OP_UNUSED_5, 0, 0, 1, 0, STATUS_INVALID, 0, 0);
        put_row(ROW_REQUEST, OP_UNUSED_6, 77, 99, 1, 0, STATUS_INVALID, 0, 0);
        put_row(ROW_REQUEST, OP_ADD, 0, 64, 1, 0, STATUS_OK, 64, 64);
        put_row(ROW_REQUEST, OP_ALLOC, 0, 0, 1, 0, STATUS_OK, 63, 64);
        put_row(ROW_REQUEST, OP_FREE, 0, 0, 1, 0, STATUS_OK, 64, 64);
        put_row(ROW_REQUEST, OP_FREE, 0, 0, 1, 0, STATUS_DOUBLE, 64, 64);
        put_row(ROW_REQUEST, OP_FREE, 64, 0, 1, 0, STATUS_INVALID, 64, 64);
        // Floor above the top: reset leaves the count at zero.
        put_row(ROW_FLOOR, OP_ALLOC, 100, 0, 0, 0, STATUS_OK, 0, 0);
        put_row(ROW_REQUEST, OP_RESET, 0, 0, 1, 0, STATUS_OK, 0, 64);
        // An empty region still raises the top.
        put_row(ROW_REQUEST, OP_ADD, 200, 150, 1, 0, STATUS_OK, 0, 150);
        put_row(ROW_FLOOR, OP_ALLOC, 16, 0, 0, 0, STATUS_OK, 0, 0);
        // A free page while the count is zero: the count stays at zero.
        put_row(ROW_REQUEST, OP_ALLOC, 0, 0, 1, 100, STATUS_OK, 0, 150);
        put_row(ROW_REQUEST, OP_FREE, 15, 0, 1, 0, STATUS_INVALID, 0, 150);
        put_row(ROW_REQUEST, OP_RESET, 0, 0, 1, 0, STATUS_OK, 134, 150);
        put_row(ROW_REQUEST, OP_ALLOC, 0, 0, 1, 16, STATUS_OK, 133, 150);
        put_row(ROW_REQUEST, OP_CLEAR, 0, 0, 1, 0, STATUS_OK, 0, 150);
        put_row(ROW_REQUEST, OP_ADD, 0, PAGE_CAP, 1, 0, STATUS_OK, 32752, PAGE_CAP);
        put_row(ROW_REQUEST, OP_ADD, 20'hFFFFF, 1048576, 1, 0, STATUS_OK, 32752, PAGE_CAP);
        put_row(ROW_FLOOR, OP_ALLOC, PAGE_CAP, 0, 0, 0, STATUS_OK, 0, 0);
        put_row(ROW_REQUEST, OP_ALLOC, 0, 0, 1, 0, STATUS_NO_FREE, 32752, PAGE_CAP);
        put_row(ROW_REQUEST, OP_RESET, 0, 0, 1, 0, STATUS_OK, 0, PAGE_CAP);
        put_row(ROW_REQUEST, OP_FREE, 32767, 0, 1, 0, STATUS_INVALID, 0, PAGE_CAP);
        put_row(ROW_FLOOR, OP_ALLOC, 0, 0, 0, 0, STATUS_OK, 0, 0);
        put_row(ROW_REQUEST, OP_ALLOC, 0, 0, 1, 0, STATUS_NO_FREE, 0, PAGE_CAP);
        // A region past capacity frees up to capacity and keeps the top.
        put_row(ROW_REQUEST, OP_ADD, 32760, 1048576, 1, 0, STATUS_OK, 8, PAGE_CAP);
        put_row(ROW_REQUEST, OP_ALLOC, 0, 0, 1, 32760, STATUS_OK, 7, PAGE_CAP);
        put_row(ROW_REQUEST, OP_FREE, 32767, 0, 1, 0, STATUS_DOUBLE, 7, PAGE_CAP);
        put_row(ROW_REQUEST, OP_FREE, 32760, 0, 0, 0, STATUS_OK, 0, 0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_FLOOR)
            begin
                set_floor(directed_rows[i].page[COUNT_W-1:0]);
            end
            else
            begin
                issue_request(directed_rows[i].op, directed_rows[i].page,
                              directed_rows[i].region, directed_rows[i].typed,
                              directed_rows[i].want);
                pause_sender($urandom_range(0, GAP_MAX));
            end
        end

        // Each phase optionally moves the floor, may reset or clear the map, adds a few
        // regions, then mixes allocate and free requests with the other operations.
        while (issued < TOTAL_REQUESTS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
            begin
                set_floor($urandom_range(0, 1024));
            end
            else if (pick < 7)
            begin
                set_floor($urandom_range(0, PAGE_CAP));
            end
            else if (pick == 7)
            begin
                set_floor(0);
            end
            else if (pick == 8)
            begin
                set_floor(PAGE_CAP);
            end
            gap_top = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;

            pick = $urandom_range(0, 9);
            if (pick < 4)
            begin
                issue_request(OP_RESET, $urandom_range(0, 20'hFFFFF), 0, 1'b0, '0);
                pause_sender($urandom_range(0, gap_top));
            end
            else if (pick < 6)
            begin
                issue_request(OP_CLEAR, 0, $urandom_range(0, 1048576), 1'b0, '0);
                pause_sender($urandom_range(0, gap_top));
            end
            repeat ($urandom_range(1, 4))
            begin
                add_near_floor();
                pause_sender($urandom_range(0, gap_top));
            end

            steps = $urandom_range(10, 40);
            repeat (steps)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                begin
                    issue_request(OP_ALLOC, $urandom_range(0, 20'hFFFFF),
                                  $urandom_range(0, 1048576), 1'b0, '0);
                end
                else if (pick < 72)
                begin
                    if (claimed_pages.size() != 0 && $urandom_range(0, 9) < 7)
                    begin
                        idx = $urandom_range(0, claimed_pages.size() - 1);
                        page = claimed_pages[idx];
                        claimed_pages.delete(idx);
                    end
                    else
                    begin
                        page = model_floor + $urandom_range(0, 300);
                    end
                    issue_request(OP_FREE, page[PAGE_W-1:0], 0, 1'b0, '0);
                end
                else if (pick < 77)
                begin
                    issue_request(OP_FREE, $urandom_range(0, 20'hFFFFF), 0, 1'b0, '0);
                end
                else if (pick < 85)
                begin
                    add_near_floor();
                end
                else if (pick < 89)
                begin
                    page = $urandom_range(0, 20'hFFFFF);
                    region = $urandom_range(0, 1048576);
                    issue_request(OP_ADD, page[PAGE_W-1:0], region[END_W-1:0], 1'b0, '0);
                end
                else if (pick < 92)
                begin
                    issue_request($urandom_range(OP_UNUSED_5, OP_UNUSED_7),
                                  $urandom_range(0, 20'hFFFFF),
                                  $urandom_range(0, 1048576), 1'b0, '0);
                end
                else if (pick < 95)
                begin
                    issue_request(OP_RESET, 0, 0, 1'b0, '0);
                end
                else if (pick < 97)
                begin
                    issue_request(OP_CLEAR, 0, 0, 1'b0, '0);
                end
                else
                begin
                    // Let the block drain completely before the next request.
                    wait_all_results();
                end
                pause_sender($urandom_range(0, gap_top));
            end
        end

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && awaited_results.size() == 0)
        begin
            $display("bitmap_page_allocator: match");
        end
        else
        begin
            $display("bitmap_page_allocator: mismatch");
        end
        $finish;
    end

endmodule
